// ----- sv/udpc_pkg.sv -----
package udpc_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned LenW = 16;
  localparam int unsigned SumW = 16;
  localparam int unsigned PosW = 16;
  localparam int unsigned HdrLen = 8;
  localparam int unsigned PhWordsV4 = 6;
  localparam int unsigned PhWordsV6 = 18;
  localparam int unsigned SrcPortOfs = 0;
  localparam int unsigned DstPortOfs = 1;
  localparam int unsigned CksumOfs = 3;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam logic CsrChecksumEnable = 1'b0;
  localparam logic ChecksumEnableRst = 1'b1;

  typedef enum logic [2:0] {
    LEN_OK        = 3'd0,
    LEN_TRUNCATED = 3'd1,
    LEN_INVALID   = 3'd2,
    LEN_SHORT     = 3'd3,
    LEN_LONG      = 3'd4
  } len_status_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             first;
    logic             last;
    logic             odd_byte;
    logic             is_ipv6;
    logic             fragmented;
    logic [LenW-1:0]  udp_length;
    logic [LenW-1:0]  captured_len;
  } in_item_t;

  typedef struct packed {
    len_status_e      length_status;
    logic             checksum_bad;
    logic             ipv6_zero_checksum;
    logic [SumW-1:0]  checksum_value;
    logic [WordW-1:0] src_port;
    logic [WordW-1:0] dst_port;
    logic             port_zero;
  } out_item_t;

endpackage

// ----- sv/udpc_outbuf.sv -----
module udpc_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  udpc_pkg::out_item_t  res_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output udpc_pkg::out_item_t  out_data_o
);
  import udpc_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;
  logic      out_fire;

  assign out_fire = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_d = res_valid_i;
      out_data_d  = res_data_i;
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/udp_datagram_checker.sv -----
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  in_data_i  (one word of a datagram)
// out      output     out_valid_o / out_stall_i out_data_o (one verdict per last word)
// cfg      input      apb psel/penable/pready  checksum_enable at byte address 0
//
// one word per cycle while in_stall_o is low; the running sum, word count and header capture
// update in the accept cycle, and a last word's verdict enters the output register or, while
// the output is stalled, the skid buffer; the output register plus a one-entry skid buffer
// decouple the two channels; in_stall_o rises only when both are full
// reset clears all datagram state and sets checksum_enable; no clearing pass
module udp_datagram_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  udpc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output udpc_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [udpc_pkg::CfgAddrW-1:0]     paddr,
  input  logic [udpc_pkg::CfgDataW-1:0]     pwdata,
  output logic [udpc_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready
);
  import udpc_pkg::*;

  logic             cksum_en_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             ipv6_q, ipv6_d;
  logic             frag_q, frag_d;
  logic [LenW-1:0]  udp_len_q, udp_len_d;
  logic [LenW-1:0]  cap_len_q, cap_len_d;
  logic             cz_q, cz_d;
  logic [WordW-1:0] sport_q, sport_d;
  logic [WordW-1:0] dport_q, dport_d;

  logic             in_fire;
  logic             buf_full;
  logic [WordW-1:0] w;
  logic [PosW-1:0]  pos_b;
  logic [SumW-1:0]  sum_b;
  logic [PosW-1:0]  ph;
  logic [SumW:0]    sum_add;
  logic [SumW-1:0]  sum_inv;
  out_item_t        res;
  logic             cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[CfgAddrW-1] == CsrChecksumEnable);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cksum_en_q <= ChecksumEnableRst;
    end else if (cfg_wr) begin
      cksum_en_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CfgAddrW-1] == CsrChecksumEnable) begin
      prdata[0] = cksum_en_q;
    end
  end

  // datagram state
  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i & ~buf_full;

  always_comb begin
    w = in_data_i.word;
    if (in_data_i.last && in_data_i.odd_byte) begin
      w[WordW/2-1:0] = '0;
    end

    ipv6_d    = ipv6_q;
    frag_d    = frag_q;
    udp_len_d = udp_len_q;
    cap_len_d = cap_len_q;
    sum_b     = sum_q;
    pos_b     = pos_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    cz_d      = cz_q;
    if (in_data_i.first) begin
      ipv6_d    = in_data_i.is_ipv6;
      frag_d    = in_data_i.fragmented;
      udp_len_d = in_data_i.udp_length;
      cap_len_d = in_data_i.captured_len;
      sum_b     = '0;
      pos_b     = '0;
      sport_d   = '0;
      dport_d   = '0;
      cz_d      = 1'b1;
    end

    ph = ipv6_d ? PosW'(PhWordsV6) : PosW'(PhWordsV4);
    priority if (pos_b == ph + PosW'(SrcPortOfs)) begin
      sport_d = w;
    end else if (pos_b == ph + PosW'(DstPortOfs)) begin
      dport_d = w;
    end else if (pos_b == ph + PosW'(CksumOfs)) begin
      cz_d = (w == '0);
    end

    // end-around carry keeps the sum within 16 bits
    sum_add = {1'b0, sum_b} + {1'b0, w};
    sum_d   = sum_add[SumW-1:0] + SumW'(sum_add[SumW]);
    pos_d   = (pos_b == '1) ? pos_b : pos_b + PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      pos_q     <= '0;
      ipv6_q    <= 1'b0;
      frag_q    <= 1'b0;
      udp_len_q <= '0;
      cap_len_q <= '0;
      cz_q      <= 1'b0;
      sport_q   <= '0;
      dport_q   <= '0;
    end else if (in_fire) begin
      sum_q     <= sum_d;
      pos_q     <= pos_d;
      ipv6_q    <= ipv6_d;
      frag_q    <= frag_d;
      udp_len_q <= udp_len_d;
      cap_len_q <= cap_len_d;
      cz_q      <= cz_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
    end
  end

  // verdict
  assign sum_inv = ~sum_d;

  always_comb begin
    res = '0;
    priority if (cap_len_d < LenW'(HdrLen)) begin
      res.length_status = LEN_TRUNCATED;
    end else if (udp_len_d < LenW'(HdrLen)) begin
      res.length_status = LEN_INVALID;
    end else if (udp_len_d > cap_len_d) begin
      res.length_status = LEN_SHORT;
    end else if (udp_len_d < cap_len_d) begin
      res.length_status = LEN_LONG;
    end else begin
      res.length_status = LEN_OK;
    end

    if (res.length_status == LEN_OK) begin
      if (cksum_en_q) begin
        priority if (!ipv6_d) begin
          if (!frag_d && !cz_d) begin
            res.checksum_value = sum_inv;
          end
        end else if (cz_d) begin
          res.ipv6_zero_checksum = 1'b1;
        end else if (!frag_d) begin
          res.checksum_value = sum_inv;
        end
        res.checksum_bad = res.ipv6_zero_checksum | (res.checksum_value != '0);
      end
      res.src_port  = sport_d;
      res.dst_port  = dport_d;
      res.port_zero = (sport_d == '0) | (dport_d == '0);
    end
  end

  udpc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (in_fire & in_data_i.last),
    .res_data_i  (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
